/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPHM_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LPHM_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lphm_pkg.sv */
// ---------------------------------------------------------------------------
// lphm_pkg
// Shared constants, result codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lphm_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int KEY_BITS       = 32;
  localparam int IN_VAL_BITS    = 32;
  localparam int OUT_VAL_BITS   = 32;
  localparam int SLOT_BITS      = 4;
  localparam int STATUS_BITS    = 3;

  localparam logic ACT_FIND = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_REJECT   = 3'd4;

  typedef struct packed {
    logic                   load;
    logic                   hash_step;
    logic                   start;
    logic                   advance;
    logic                   clear;
    logic                   insert;
    logic                   res_we;
    logic [STATUS_BITS-1:0] res_code;
    logic                   emit;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic hash_last;
    logic clr_last;
    logic match;
    logic empty;
    logic probe_last;
    logic act;
    logic out_free;
  } sts_t;

endpackage

/* rtl/lphm_ram.sv */
// ---------------------------------------------------------------------------
// lphm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module lphm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lphm_dp.sv */
// ---------------------------------------------------------------------------
// lphm_dp
// Datapath: input word capture, home slot unit, probe index, table RAM,
// result staging and output register.
// ---------------------------------------------------------------------------
module lphm_dp
  import lphm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_action,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic [IN_VAL_BITS-1:0]  in_value,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_BITS-1:0]  out_status,
  output logic [OUT_VAL_BITS-1:0] out_value,
  output logic [SLOT_BITS-1:0]    out_slot
);

  localparam int IW  = $clog2(SLOTS);
  localparam int RW  = KEY_BITS + VALUE_BITS;
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

  logic                   act_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [VALUE_BITS-1:0]  val_q;
  logic [IW-1:0]          home;
  logic                   hash_last;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          idx_next;
  logic [IW-1:0]          cnt;
  logic [IW-1:0]          raddr;
  logic [RW-1:0]          wdata;
  logic [RW-1:0]          rdata;
  logic [KEY_BITS-1:0]    rd_key;
  logic [VALUE_BITS-1:0]  rd_val;
  logic [STATUS_BITS-1:0] res_code;
  logic [OUT_VAL_BITS-1:0] res_val;
  logic [SLOT_BITS-1:0]   res_slot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= in_action;
      key_q <= in_key;
      val_q <= VALUE_BITS'(in_value);
    end
  end

  // home slot = key mod SLOTS
  generate
    if (POW2) begin : g_mask
      assign home      = key_q[IW-1:0];
      assign hash_last = 1'b1;
    end else begin : g_recip
      // quotient = (key * M) >> (KEY_BITS + IW) with M = ceil(2^(KEY_BITS+IW) / SLOTS),
      // exact for every key; three steps keep each multiplier at 32 x 17 or less
      localparam logic [63:0] M = ((64'd1 << (KEY_BITS + IW)) + 64'(SLOTS - 1)) /
                                  64'(SLOTS);
      localparam logic [15:0] M_LO = M[15:0];
      localparam logic [16:0] M_HI = M[32:16];
      localparam int          AW   = KEY_BITS + 33;
      logic [1:0]           phase;
      logic [KEY_BITS+15:0] p_lo;
      logic [KEY_BITS+16:0] p_hi;
      logic [AW-1:0]        acc;
      logic [KEY_BITS-1:0]  quo;
      logic [IW-1:0]        rem;

      assign p_hi = key_q * M_HI;
      assign quo  = KEY_BITS'(acc >> (KEY_BITS + IW));

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          phase <= '0;
        end else if (cmd.hash_step) begin
          phase <= phase + 2'd1;
          case (phase)
            2'd0: begin
              p_lo <= key_q * M_LO;
            end
            2'd1: begin
              acc <= AW'(p_lo) + {p_hi, 16'b0};
            end
            default: begin
              rem <= IW'(key_q - quo * KEY_BITS'(SLOTS));
            end
          endcase
        end
      end

      assign home      = rem;
      assign hash_last = (phase == 2'd2);
    end
  endgenerate

  assign idx_next = (idx == IW'(SLOTS - 1)) ? '0 : idx + IW'(1);

  // idx doubles as the clear sweep pointer after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cnt <= '0;
    end else if (cmd.start) begin
      idx <= home;
      cnt <= '0;
    end else if (cmd.advance || cmd.clear) begin
      idx <= idx_next;
      cnt <= cnt + IW'(1);
    end
  end

  // read runs one slot ahead of the compare
  assign raddr = cmd.start ? home : idx_next;
  assign wdata = cmd.clear ? '0 : {val_q, key_q};

  lphm_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.clear | cmd.insert),
    .waddr (idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key = rdata[KEY_BITS-1:0];
  assign rd_val = rdata[KEY_BITS +: VALUE_BITS];

  always_comb begin
    sts.key_zero   = (key_q == '0);
    sts.hash_last  = hash_last;
    sts.clr_last   = (idx == IW'(SLOTS - 1));
    sts.match      = (rd_key == key_q);
    sts.empty      = (rd_key == '0);
    sts.probe_last = (cnt == IW'(SLOTS - 1));
    sts.act        = act_q;
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_code <= cmd.res_code;
      case (cmd.res_code) inside
        ST_FOUND, ST_PRESENT: begin
          res_val  <= OUT_VAL_BITS'(rd_val);
          res_slot <= SLOT_BITS'(idx);
        end
        ST_INSERTED: begin
          res_val  <= OUT_VAL_BITS'(val_q);
          res_slot <= SLOT_BITS'(idx);
        end
        default: begin
          res_val  <= '0;
          res_slot <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_code;
      out_value  <= res_val;
      out_slot   <= res_slot;
    end
  end

endmodule

/* rtl/lphm_ctrl.sv */
// ---------------------------------------------------------------------------
// lphm_ctrl
// Controller: clear sweep, home slot, probe walk and result hand-off.
// ---------------------------------------------------------------------------
module lphm_ctrl
  import lphm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.key_zero) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_REJECT;
          state_next   = S_DONE;
        end else begin
          cmd.hash_step = 1'b1;
          if (sts.hash_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        state_next = S_DONE;
        cmd.res_we = 1'b1;
        if (sts.act == ACT_SET) begin
          if (sts.empty) begin
            cmd.insert   = 1'b1;
            cmd.res_code = ST_INSERTED;
          end else if (sts.match) begin
            cmd.res_code = ST_PRESENT;
          end else if (sts.probe_last) begin
            cmd.res_code = ST_REJECT;
          end else begin
            cmd.res_we  = 1'b0;
            cmd.advance = 1'b1;
            state_next  = S_PROBE;
          end
        end else begin
          if (sts.match) begin
            cmd.res_code = ST_FOUND;
          end else if (sts.probe_last) begin
            cmd.res_code = ST_MISS;
          end else begin
            cmd.res_we  = 1'b0;
            cmd.advance = 1'b1;
            state_next  = S_PROBE;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/linear_probe_hash_map.sv */
// Sequence: the input word is loaded, the home slot found (by reciprocal remainder
// unless SLOTS is a power of two), 1 to SLOTS slots probed, the result staged and
// emitted; a key of zero is rejected before any probe.
// Throughput: one word in flight, next word taken only once the result is emitted;
// the table RAM read port sets the one-slot-per-cycle walk.
// Reset: synchronous; every slot of the key store swept to empty, s_axis_tready low.
// ---------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressing hash map with linear probing; find and set requests.
// ---------------------------------------------------------------------------
module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value_out[31:0], slot[35:32], zero pad
  output logic [2:0]  m_axis_tuser    // status
);

  `include "assert_macros.svh"

  cmd_t                    cmd;
  sts_t                    sts;
  logic [OUT_VAL_BITS-1:0] value_out;
  logic [SLOT_BITS-1:0]    slot;

  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lphm_dp #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_action  (s_axis_tuser),
    .in_key     (s_axis_tdata[31:0]),
    .in_value   (s_axis_tdata[63:32]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_value  (value_out),
    .out_slot   (slot)
  );

  assign m_axis_tdata = {4'b0, slot, value_out};

  `LPHM_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
             "input accepted while a word is still in flight")
  `LPHM_IMPLY(a_status_range, m_axis_tvalid,
              m_axis_tuser == ST_FOUND || m_axis_tuser == ST_MISS ||
              m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_PRESENT ||
              m_axis_tuser == ST_REJECT, "result status out of range")
  `LPHM_IMPLY(a_zero_fields, m_axis_tvalid &&
              (m_axis_tuser == ST_MISS || m_axis_tuser == ST_REJECT),
              value_out == '0 && slot == '0, "miss or reject with nonzero fields")

endmodule
